// ===== hw/rtl/sdwi_pkg.sv =====
`timescale 1ns / 1ps

package sdwi_pkg;

  // Capacity of one list and the widths that follow from it
  localparam int MAX_ITEMS = 16;
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int KEY_W = 32;
  localparam int TAG_W = 8;

  // One stored entry: key with its tag
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
  } ent_t;

  // Write port request into the entry store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    ent_t             data;
  } wr_req_t;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    S_LOAD      = 7'b0000001,
    S_CARRY     = 7'b0000010,
    S_CMP       = 7'b0000100,
    S_FLUSH     = 7'b0001000,
    S_EMIT_RD   = 7'b0010000,
    S_EMIT_LOAD = 7'b0100000,
    S_EMIT_HOLD = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/sdwi_store.sv =====
`timescale 1ns / 1ps

module sdwi_store import sdwi_pkg::*; (
  input  logic             clk_i,
  input  wr_req_t          wr_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output ent_t             rd_data_o
);

  ent_t mem_q [MAX_ITEMS];
  ent_t rd_data_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/sort_desc_with_index_top.sv =====
`timescale 1ns / 1ps
// Load: one key per cycle; the last key of a list starts the sort.
// Sort of n stored keys: n-1 bubble passes over the entry store (one write port and
// one registered read port), each pass a carry step, one compare per pair and a flush step.
// Emit: per result one store read and one output beat held until taken; input stalled
// from the last key until the final result is taken.
// Reset clears the fill count, the drop flag and the sequencer; store contents stay undefined.

module sort_desc_with_index_top import sdwi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [KEY_W-1:0] key_value_i,
  input  logic        [TAG_W-1:0] tag_i,
  input  logic                    last_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [KEY_W-1:0] sorted_value_o,
  output logic        [TAG_W-1:0] sorted_tag_o,
  output logic                    last_out_o,
  output logic                    overflow_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             drop_q, drop_d;
  logic [IDX_W-1:0] pass_len_q, pass_len_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [IDX_W-1:0] e_q, e_d;
  ent_t             carry_q, carry_d;
  ent_t             out_q, out_d;
  logic             out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;

  wr_req_t          wr;
  logic [IDX_W-1:0] rd_addr;
  ent_t             rd_data;
  logic             in_acc;
  logic             out_acc;
  logic             room;
  logic [CNT_W-1:0] cnt_now;

  sdwi_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o  = (state_q != S_LOAD);
  assign out_valid_o = (state_q == S_EMIT_HOLD);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign room        = (fill_q < CNT_W'(MAX_ITEMS));
  assign cnt_now     = room ? (fill_q + 1'b1) : fill_q;

  // Sequence load, bubble passes and emit
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    drop_d     = drop_q;
    pass_len_d = pass_len_q;
    j_d        = j_q;
    e_d        = e_q;
    carry_d    = carry_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    wr         = '0;
    rd_addr    = '0;

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (room) begin
            wr.en       = 1'b1;
            wr.addr     = fill_q[IDX_W-1:0];
            wr.data.key = key_value_i;
            wr.data.tag = tag_i;
            fill_d      = fill_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (last_in_i) begin
            e_d        = '0;
            pass_len_d = IDX_W'(cnt_now - 1'b1);
            if (cnt_now == CNT_W'(1)) begin
              state_d = S_EMIT_RD;
            end else begin
              state_d = S_CARRY;
            end
          end
        end
      end
      S_CARRY: begin
        // Take entry 0 as the sinking element, fetch entry 1
        carry_d = rd_data;
        rd_addr = IDX_W'(1);
        j_d     = '0;
        state_d = S_CMP;
      end
      S_CMP: begin
        wr.en   = 1'b1;
        wr.addr = j_q;
        if (carry_q.key < rd_data.key) begin
          wr.data = rd_data;
        end else begin
          wr.data = carry_q;
          carry_d = rd_data;
        end
        if (j_q == IDX_W'(pass_len_q - 1'b1)) begin
          state_d = S_FLUSH;
        end else begin
          rd_addr = IDX_W'(j_q + 2'd2);
          j_d     = j_q + 1'b1;
        end
      end
      S_FLUSH: begin
        // Drop the smallest element of this pass at its final place
        wr.en   = 1'b1;
        wr.addr = pass_len_q;
        wr.data = carry_q;
        rd_addr = '0;
        if (pass_len_q == IDX_W'(1)) begin
          state_d = S_EMIT_LOAD;
        end else begin
          pass_len_d = pass_len_q - 1'b1;
          state_d    = S_CARRY;
        end
      end
      S_EMIT_RD: begin
        rd_addr = e_q;
        state_d = S_EMIT_LOAD;
      end
      S_EMIT_LOAD: begin
        out_d      = rd_data;
        out_last_d = ((CNT_W'(e_q) + 1'b1) == fill_q);
        out_ovf_d  = drop_q;
        state_d    = S_EMIT_HOLD;
      end
      S_EMIT_HOLD: begin
        // Hold the beat, prefetch the next entry
        rd_addr = out_last_q ? e_q : IDX_W'(e_q + 1'b1);
        if (out_acc) begin
          if (out_last_q) begin
            fill_d  = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            e_d     = e_q + 1'b1;
            state_d = S_EMIT_LOAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fill_q  <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pass_len_q <= pass_len_d;
    j_q        <= j_d;
    e_q        <= e_d;
    carry_q    <= carry_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign sorted_value_o = out_q.key;
  assign sorted_tag_o   = out_q.tag;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

  // Fill count never exceeds capacity
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_ITEMS))
    else $error("fill count above capacity");

  // A drop only happens on a full store
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (fill_q == CNT_W'(MAX_ITEMS)))
    else $error("drop flag set with room left");

  // Each pass stays inside the stored entries
  a_pass_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP || state_q == S_FLUSH) |->
      (pass_len_q != '0 && CNT_W'(pass_len_q) < fill_q && j_q < pass_len_q))
    else $error("bubble pass out of range");

  // Emitted index stays below the list length
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CNT_W'(e_q) < fill_q))
    else $error("emit index beyond list");

  // A final beat returns the block to loading
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_out_o) |=> (state_q == S_LOAD && fill_q == '0))
    else $error("list not closed after final beat");

endmodule
